@@ hdl/fta_pkg.sv @@
package fta_pkg;

	localparam int WIN_DEPTH  = 64;
	localparam int PTR_W      = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int COUNT_W    = $clog2(WIN_DEPTH + 1);
	localparam int DUR_W      = 32;
	localparam int SUM_W      = DUR_W + ((WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 0);
	localparam int TS_W       = 64;
	localparam int TPS_W      = 32;
	localparam int TICKS_W    = TPS_W + 2;
	localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

	localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

	typedef enum logic {
		OP_RESTART = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

endpackage

@@ hdl/fta_ram.sv @@
module fta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/fta_div.sv @@
// Restoring divider, one quotient bit per cycle.
module fta_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fta_pkg::SUM_W-1:0]   dividend,
	input  logic [fta_pkg::COUNT_W-1:0] divisor,
	output logic                        done,
	output logic [fta_pkg::DUR_W-1:0]   quotient
);

	import fta_pkg::*;

	logic [SUM_W-1:0]     quo_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [COUNT_W:0]     trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top trial bit drops out
			rem_q <= fits ? COUNT_W'(trial - {1'b0, divisor}) : trial[COUNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[DUR_W-1:0];

endmodule

@@ hdl/frame_time_averager_core.sv @@
// Frame time averager. Each item is a timestamped event: a restart loads the
// reference time, a tick measures the frame duration since the last event
// (saturated to 32 bits), pushes it into a 64-deep window when it lies within
// one second of the current mean, and updates the mean and the frames-per-
// second figure. Every item yields exactly one result carrying the mean,
// the latched rate and the window fill. A restart goes from the accepting
// state to the finishing state, which loads the output register. A tick
// first updates the window and starts the bit-serial divider that forms
// sum / count; the divider yields its SUM_W quotient bits, the quotient is
// taken into the mean, and the finishing state loads the output register.
// The input is ready again from the cycle the result appears, so no new
// item is taken before the last is through. One item is worked on at a
// time; a new item is taken while the previous result still waits on the
// output, and a finished item holds until that output register frees. The
// window lives in a circular buffer RAM; the running sum drops the oldest
// entry once the window is full, so no sweep over the window and no clearing
// pass after reset are needed. ticks_per_second resets to 1000; the user
// must write it only while the block is idle; the block does not enforce it.
module frame_time_averager_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [fta_pkg::TPS_W-1:0]    cfg_data,
	// input items
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [fta_pkg::TS_W-1:0]     timestamp,
	// result items
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fta_pkg::DUR_W-1:0]    average_frame_ticks,
	output logic [31:0]                  frame_rate,
	output logic [fta_pkg::COUNT_W-1:0]  samples_held
);

	import fta_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t             state_q;

	logic [TPS_W-1:0]   tps_q;
	logic [TS_W-1:0]    ref_q;
	logic [PTR_W-1:0]   wp_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [DUR_W-1:0]   mean_q;
	logic [31:0]        frames_q;
	logic [TICKS_W-1:0] ticks_q;
	logic [31:0]        rate_q;
	logic               div_start_q;

	logic [DUR_W-1:0]   dur_s1;

	logic               out_valid_q;
	logic [DUR_W-1:0]   out_mean_q;
	logic [31:0]        out_rate_q;
	logic [COUNT_W-1:0] out_count_q;

	logic               accept;
	logic [TS_W-1:0]    diff;
	logic [DUR_W-1:0]   dur_sat;
	logic [DUR_W-1:0]   old_dur;
	logic [DUR_W-1:0]   dev;
	logic               take;
	logic               full;
	logic [SUM_W-1:0]   sum_next;
	logic [TICKS_W-1:0] ticks_next;
	logic               div_done;
	logic [DUR_W-1:0]   div_quo;
	logic               out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// duration since the last event, modulo 2^64, clamped to 32 bits
	assign diff    = timestamp - ref_q;
	assign dur_sat = (diff[TS_W-1:DUR_W] != '0) ? '1 : diff[DUR_W-1:0];

	// window acceptance: |d - mean| < ticks per second
	assign dev  = (dur_s1 >= mean_q) ? (dur_s1 - mean_q) : (mean_q - dur_s1);
	assign take = (dev < tps_q);
	assign full = (count_q == COUNT_W'(WIN_DEPTH));

	// running sum; the slot at the write pointer holds the oldest duration
	// once the window is full
	assign sum_next = sum_q + SUM_W'(dur_s1) - (full ? SUM_W'(old_dur) : '0);
	assign ticks_next = ticks_q + TICKS_W'(dur_s1);

	fta_ram #(
		.WIDTH (DUR_W),
		.DEPTH (WIN_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (state_q == ST_PUSH && take),
		.waddr (wp_q),
		.wdata (dur_s1),
		.raddr (wp_q),
		.rdata (old_dur)
	);

	fta_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tps_q       <= TPS_RESET;
			ref_q       <= '0;
			wp_q        <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			mean_q      <= '0;
			frames_q    <= '0;
			ticks_q     <= '0;
			rate_q      <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (cfg_we) begin
				tps_q <= cfg_data;
			end
			// a finished item refills the output register as it drains
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ref_q <= timestamp;
						// window read for the oldest entry is issued this cycle
						state_q <= (op_t'(operation) == OP_TICK) ? ST_PUSH : ST_FIN;
					end
				end
				ST_PUSH: begin
					if (take) begin
						sum_q <= sum_next;
						wp_q  <= (wp_q == PTR_W'(WIN_DEPTH - 1)) ? '0 : wp_q + 1'b1;
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end
					if (ticks_next > TICKS_W'(tps_q)) begin
						rate_q   <= frames_q + 1'b1;
						frames_q <= '0;
						ticks_q  <= '0;
					end else begin
						frames_q <= frames_q + 1'b1;
						ticks_q  <= ticks_next;
					end
					div_start_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						mean_q  <= (count_q == '0) ? '0 : div_quo;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dur_s1 <= dur_sat;
		end
		if (state_q == ST_FIN && out_free) begin
			out_mean_q  <= mean_q;
			out_rate_q  <= rate_q;
			out_count_q <= count_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign average_frame_ticks = out_mean_q;
	assign frame_rate          = out_rate_q;
	assign samples_held        = out_count_q;

endmodule

@@ tb/frame_stats_checker.sv @@
module frame_stats_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [fta_pkg::TPS_W-1:0]   cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        operation,
	input  logic [fta_pkg::TS_W-1:0]    timestamp,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [fta_pkg::DUR_W-1:0]   average_frame_ticks,
	input  logic [31:0]                 frame_rate,
	input  logic [fta_pkg::COUNT_W-1:0] samples_held,
	output int                          mismatch_count,
	output int                          stats_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import fta_pkg::*;

	typedef struct packed {
		logic [DUR_W-1:0]   avg_ticks;
		logic [31:0]        rate;
		logic [COUNT_W-1:0] held;
	} frame_stats_t;

	// shadow copy of the block's state
	logic [TPS_W-1:0]   tps;
	logic [TS_W-1:0]    ref_ts;
	logic [DUR_W-1:0]   durations [WIN_DEPTH];
	logic [COUNT_W-1:0] held;
	logic [DUR_W-1:0]   mean;
	logic [31:0]        frames;
	logic [63:0]        sec_ticks;
	logic [31:0]        rate;

	frame_stats_t stats_due [$];

	task automatic clear_state();
		tps       = TPS_RESET;
		ref_ts    = '0;
		held      = '0;
		mean      = '0;
		frames    = '0;
		sec_ticks = '0;
		rate      = '0;
		for (int i = 0; i < WIN_DEPTH; i++)
			durations[i] = '0;
	endtask

	task automatic predict_frame_stats(input op_t op, input logic [TS_W-1:0] ts,
			output frame_stats_t res);
		logic [TS_W-1:0]  gap;
		logic [DUR_W-1:0] dur;
		logic [DUR_W:0]   dev;
		logic [SUM_W-1:0] sum;
		if (op == OP_RESTART) begin
			ref_ts = ts;
		end else begin
			gap    = ts - ref_ts;
			dur    = (gap > 64'hFFFF_FFFF) ? '1 : gap[DUR_W-1:0];
			ref_ts = ts;
			dev = (dur >= mean) ? {1'b0, dur} - {1'b0, mean} : {1'b0, mean} - {1'b0, dur};
			// close to the mean: newest duration goes in front, oldest drops out
			if (dev < {1'b0, tps}) begin
				for (int i = WIN_DEPTH - 1; i > 0; i--)
					durations[i] = durations[i-1];
				durations[0] = dur;
				if (held < WIN_DEPTH)
					held = held + 1'b1;
			end
			frames    = frames + 1;
			sec_ticks = sec_ticks + dur;
			if (sec_ticks > tps) begin
				rate      = frames;
				frames    = '0;
				sec_ticks = '0;
			end
			sum = '0;
			for (int i = 0; i < WIN_DEPTH; i++)
				if (i < held)
					sum = sum + durations[i];
			mean = (held != 0) ? DUR_W'(sum / held) : '0;
		end
		res = '{mean, rate, held};
	endtask

	function automatic int field_miss(string name, logic [31:0] want, logic [31:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		frame_stats_t want;
		frame_stats_t got;
		int errs;
		if (!arst_n) begin
			clear_state();
			stats_due.delete();
			mismatch_count    <= 0;
			stats_outstanding <= 0;
		end else begin
			errs = 0;
			if (cfg_we)
				tps = cfg_data;
			if (out_valid && out_ready) begin
				got = '{average_frame_ticks, frame_rate, samples_held};
				if (stats_due.size() == 0) begin
					$display("%0t: result with no item outstanding, expected none, actual %0d %0d %0d",
						$time, got.avg_ticks, got.rate, got.held);
					errs++;
				end else begin
					want = stats_due.pop_front();
					errs += field_miss("average_frame_ticks", want.avg_ticks, got.avg_ticks);
					errs += field_miss("frame_rate", want.rate, got.rate);
					errs += field_miss("samples_held", 32'(want.held), 32'(got.held));
				end
			end
			if (in_valid && in_ready) begin
				predict_frame_stats(op_t'(operation), timestamp, want);
				stats_due.push_back(want);
			end
			mismatch_count    <= mismatch_count + errs;
			stats_outstanding <= stats_due.size();
		end
	end

endmodule

@@ tb/frame_time_averager_core_tb.sv @@
module frame_time_averager_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fta_pkg::*;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [TPS_W-1:0]   cfg_data  = '0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic               operation = 1'b0;
	logic [TS_W-1:0]    timestamp = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [DUR_W-1:0]   average_frame_ticks;
	logic [31:0]        frame_rate;
	logic [COUNT_W-1:0] samples_held;

	int mismatch_count;
	int stats_outstanding;

	// calm: neither side idles; hold_len: one long output stall, in cycles
	bit              calm     = 1'b0;
	int              hold_len = 0;
	logic [TS_W-1:0] now_ts   = '0;
	logic [TPS_W-1:0] tps_rand;

	frame_time_averager_core u_dut (.*);

	frame_stats_checker u_stats (.*);

	always #1 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Offer one item; returns at the edge where it is taken. The valid stays
	// high if the next item follows without a gap.
	task automatic send_frame(input op_t op, input logic [TS_W-1:0] ts);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		timestamp <= ts;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic tick_at(input logic [TS_W-1:0] ts);
		now_ts = ts;
		send_frame(OP_TICK, ts);
	endtask

	task automatic tick_after(input logic [TS_W-1:0] delta);
		tick_at(now_ts + delta);
	endtask

	task automatic restart_at(input logic [TS_W-1:0] ts);
		now_ts = ts;
		send_frame(OP_RESTART, ts);
	endtask

	// Stop offering and wait for every outstanding result, plus a margin.
	// The first edge lets the item count catch the last acceptance.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (stats_outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ticks_per_second only changes while the block is idle
	task automatic write_tps(input logic [TPS_W-1:0] value);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Mostly a steady frame cadence with a little jitter, sprinkled with
	// restarts, long stalls, clock steps backward and random timestamps.
	task automatic run_phase(input logic [TPS_W-1:0] tps, input logic [31:0] period,
			input int count, input bit quiet);
		logic [31:0] jit;
		int          pick;
		op_t         op;
		write_tps(tps);
		calm = quiet;
		jit  = period >> 3;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			op   = OP_TICK;
			if (pick < 80) begin
				now_ts += period - jit + $urandom_range(0, 2 * jit);
			end else if (pick < 86) begin
				op = OP_RESTART;
				now_ts += $urandom_range(0, period);
			end else if (pick < 92) begin
				now_ts += {$urandom, $urandom} >> $urandom_range(0, 63);
			end else if (pick < 96) begin
				now_ts -= $urandom_range(1, 1000);
			end else begin
				op     = op_t'($urandom_range(0, 1));
				now_ts = {$urandom, $urandom};
			end
			send_frame(op, now_ts);
		end
		calm = 1'b0;
	endtask

	// Result side: random stalls per item, or one long hold-off on request.
	initial begin : result_sink
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_len != 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				gap = calm ? 0 : $urandom_range(0, 8);
				if (gap != 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset rate: short cadence, then a zero-length frame.
		restart_at('0);
		tick_after(16);
		tick_after(16);
		tick_after(17);
		tick_after(0);
		// Counter wraps from all ones to zero: duration of one.
		restart_at('1);
		tick_after(1);
		// Far from the mean: kept out of the window, but closes the second.
		tick_after(5000);
		// Time going backward saturates the duration.
		restart_at(64'h8000_0000_0000_0000);
		tick_at(64'd100);
		// Exactly 2^32 saturates, 2^32-1 passes as is.
		tick_after(64'h1_0000_0000);
		tick_after(64'hFFFF_FFFF);
		tick_at('1);

		// Zero ticks per second: nothing enters the window.
		write_tps('0);
		tick_after(10);
		tick_after(0);
		restart_at('0);
		tick_after(7);

		// Widest acceptance band.
		write_tps('1);
		tick_after(64'hFFFF_FFFE);
		tick_after(1);
		tick_after(64'h7FFF_FFFF);

		// Narrowest band: only an exact match with the mean gets in.
		write_tps(32'd1);
		tick_after(0);
		tick_after(1);
		tick_after(0);

		// Random part over several rates.
		run_phase(32'd1000, 32'd16, 130, 1'b0);
		run_phase(32'd1, 32'd0, 130, 1'b0);
		run_phase('1, 32'h0100_0000, 130, 1'b0);
		run_phase('0, 32'd100, 130, 1'b0);
		run_phase(32'd60000, 32'd1000, 130, 1'b1);
		tps_rand = $urandom;
		run_phase(tps_rand, tps_rand / $urandom_range(30, 240), 130, 1'b0);
		// Back-to-back items against a long output stall fills the block.
		hold_len = 400;
		run_phase(32'd1000, 32'd17, 130, 1'b1);
		run_phase(32'd10_000_000, 32'd166_667, 130, 1'b0);

		wait_drained();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && stats_outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
